@@ hw/rtl/uniform_lbp_3x3_core_macros.svh @@
// Assertion macros used by the checker file of the LBP core.
`ifndef UNIFORM_LBP_3X3_CORE_MACROS_SVH
`define UNIFORM_LBP_3X3_CORE_MACROS_SVH

// Clocked assertion, muted while reset is low.
`define LBP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define LBP_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lbp_pkg.sv @@
// Shared types, constants and the uniform-pattern label table of the LBP core.
`default_nettype none
package lbp_pkg;

    localparam int PIX_W         = 8;
    localparam int LBL_W         = 6;
    localparam int CFG_W         = 11;
    localparam int ROW_W         = 10;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int MIN_SIZE      = 3;
    localparam int BORDER        = 2;
    localparam int LABEL_MAX     = 58;
    localparam int CODE_W        = 8;
    localparam int LUT_DEPTH     = 256;
    localparam int MAX_TRANS     = 2;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;
        logic last;
    } t_flags;

    typedef logic [LBL_W-1:0] t_lut [LUT_DEPTH];

    function automatic t_lut build_lut();
        t_lut              lut;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] rot;
        int                rank;
        rank = 0;
        for (int v = 0; v < LUT_DEPTH; v++) begin
            code = CODE_W'(v);
            rot  = {code[0], code[CODE_W-1:1]};
            if ($countones(code ^ rot) <= MAX_TRANS) begin
                rank   = rank + 1;
                lut[v] = LBL_W'(rank);
            end else begin
                lut[v] = '0;
            end
        end
        return lut;
    endfunction

    localparam t_lut LABEL_LUT = build_lut();

endpackage
`default_nettype wire

@@ hw/rtl/lbp_ifs.sv @@
// Pixel and label stream interfaces of the LBP core.
`default_nettype none
interface lbp_pix_if import lbp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_lbl_if import lbp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LBL_W-1:0] label;
    logic             last;

    modport source (output valid, output label, output last, input ready);
    modport sink   (input valid, input label, input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lbp_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lbp_ram import lbp_pkg::*; #(
    parameter int WIDTH = 2 * PIX_W,
    parameter int DEPTH = MAX_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/lbp_cfg.sv @@
// APB register file and effective frame size of the LBP core.
`default_nettype none
module lbp_cfg import lbp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int WW       = $clog2(MAX_WIDTH) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [WW-1:0]     o_eff_w,
    output logic [CFG_W-1:0]  o_eff_h
);

    localparam int EW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             w_wr;
    logic             w_idx;
    logic [EW-1:0]    w_wext;
    logic [EW-1:0]    w_weff;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign w_wext = EW'(r_width);

    always_comb begin
        if (w_wext < EW'(MIN_SIZE)) begin
            w_weff = EW'(MIN_SIZE);
        end else if (w_wext > EW'(MAX_WIDTH)) begin
            w_weff = EW'(MAX_WIDTH);
        end else begin
            w_weff = w_wext;
        end
    end

    assign o_eff_w = w_weff[WW-1:0];

    always_comb begin
        if (r_height < CFG_W'(MIN_SIZE)) begin
            o_eff_h = CFG_W'(MIN_SIZE);
        end else if (r_height > CFG_W'(HEIGHT_LIMIT)) begin
            o_eff_h = CFG_W'(HEIGHT_LIMIT);
        end else begin
            o_eff_h = r_height;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lbp_scan.sv @@
// Raster position counters and interior / end-of-frame flags.
`default_nettype none
module lbp_scan import lbp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int WW       = CW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [WW-1:0]    i_eff_w,
    input  logic [CFG_W-1:0] i_eff_h,
    output logic [CW-1:0]    o_col,
    output t_flags           o_flags
);

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [WW-1:0]    w_col_x;
    logic [CFG_W-1:0] w_row_x;
    logic [WW-1:0]    w_col_p1;
    logic [CFG_W-1:0] w_row_p1;

    assign w_col_x  = WW'(r_col);
    assign w_row_x  = CFG_W'(r_row);
    assign w_col_p1 = w_col_x + WW'(1);
    assign w_row_p1 = w_row_x + CFG_W'(1);

    assign o_col        = r_col;
    assign o_flags.emit = (w_row_x >= CFG_W'(BORDER)) && (w_col_x >= WW'(BORDER))
                       && (w_row_x < i_eff_h) && (w_col_x < i_eff_w);
    assign o_flags.last = (w_row_x == i_eff_h - CFG_W'(1)) && (w_col_x == i_eff_w - WW'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_p1 >= i_eff_w) begin
            n_col = '0;
            if (w_row_p1 >= i_eff_h) begin
                n_row = '0;
            end else begin
                n_row = w_row_p1[ROW_W-1:0];
            end
        end else begin
            n_col = w_col_p1[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lbp_win.sv @@
// Line-buffer read stage, 3x3 window, LBP code, label lookup and output register.
`default_nettype none
module lbp_win import lbp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [CW-1:0]      i_col,
    input  t_flags             i_flags,
    input  logic [2*PIX_W-1:0] i_rd_data,
    output logic               o_ready,
    output logic               o_acc,
    output logic               o_we,
    output logic [CW-1:0]      o_waddr,
    output logic [2*PIX_W-1:0] o_wdata,
    lbp_lbl_if.source          o_lbl
);

    logic              r_s1_vld;
    logic [PIX_W-1:0]  r_px;
    logic [CW-1:0]     r_col;
    t_flags            r_flg;

    logic [PIX_W-1:0]  r_t1, r_t2, r_m1, r_m2, r_b1, r_b2;

    logic              r_out_vld;
    logic [LBL_W-1:0]  r_label;
    logic              r_last;

    logic              w_adv;
    logic [PIX_W-1:0]  w_top;
    logic [PIX_W-1:0]  w_mid;
    logic [PIX_W-1:0]  w_ctr;
    logic [CODE_W-1:0] w_code;

    assign w_adv   = r_s1_vld && (!r_flg.emit || !r_out_vld || o_lbl.ready);
    assign o_ready = !r_s1_vld || w_adv;
    assign o_acc   = i_valid && o_ready;

    assign w_top = i_rd_data[2*PIX_W-1:PIX_W];
    assign w_mid = i_rd_data[PIX_W-1:0];

    // shift the buffered rows down by one at this column
    assign o_we    = w_adv;
    assign o_waddr = r_col;
    assign o_wdata = {w_mid, r_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_acc) begin
            r_px  <= i_pixel;
            r_col <= i_col;
            r_flg <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_m1 <= '0;
            r_m2 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (w_adv) begin
            r_t1 <= r_t2;
            r_t2 <= w_top;
            r_m1 <= r_m2;
            r_m2 <= w_mid;
            r_b1 <= r_b2;
            r_b2 <= r_px;
        end
    end

    // centre is the old middle-right pixel once the window shifts
    assign w_ctr     = r_m2;
    assign w_code[0] = r_m1  >= w_ctr;
    assign w_code[1] = r_b1  >= w_ctr;
    assign w_code[2] = r_b2  >= w_ctr;
    assign w_code[3] = r_px  >= w_ctr;
    assign w_code[4] = w_mid >= w_ctr;
    assign w_code[5] = w_top >= w_ctr;
    assign w_code[6] = r_t2  >= w_ctr;
    assign w_code[7] = r_t1  >= w_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_flg.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_lbl.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_flg.emit) begin
            r_label <= LABEL_LUT[w_code];
            r_last  <= r_flg.last;
        end
    end

    assign o_lbl.valid = r_out_vld;
    assign o_lbl.label = r_label;
    assign o_lbl.last  = r_last;

endmodule
`default_nettype wire

@@ hw/rtl/uniform_lbp_3x3_core.sv @@
// Top level of the 3x3 uniform local binary pattern core.
// Takes one 8-bit pixel per clock in raster order while the label output is
// not stalled, and returns one 6-bit uniform LBP label (rank 1..58, 0 for
// non-uniform) per interior pixel, with last set on the final interior pixel
// of the frame; border pixels give no beat. Throughput is one pixel per cycle
// while the output is not stalled. A label's last pixel passes the registered
// read of the line-buffer RAM (both previous rows in one 16-bit word of
// MAX_WIDTH entries), then the window compare and label lookup into the output
// register. Line buffers are not cleared; the first two rows of a frame never
// produce a label. Program image_width and image_height only while idle.
`default_nettype none
module uniform_lbp_3x3_core import lbp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lbp_pix_if.sink           i_pix,
    lbp_lbl_if.source         o_lbl,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic [WW-1:0]      w_eff_w;
    logic [CFG_W-1:0]   w_eff_h;
    logic               w_acc;
    logic               w_ready;
    logic [CW-1:0]      w_col;
    t_flags             w_flags;
    logic               w_we;
    logic [CW-1:0]      w_waddr;
    logic [2*PIX_W-1:0] w_wdata;
    logic [2*PIX_W-1:0] w_rdata;

    assign i_pix.ready = w_ready;

    lbp_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_eff_w (w_eff_w),
        .o_eff_h (w_eff_h)
    );

    lbp_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_eff_w (w_eff_w),
        .i_eff_h (w_eff_h),
        .o_col   (w_col),
        .o_flags (w_flags)
    );

    lbp_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_acc),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    lbp_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .i_pixel   (i_pix.pixel),
        .i_col     (w_col),
        .i_flags   (w_flags),
        .i_rd_data (w_rdata),
        .o_ready   (w_ready),
        .o_acc     (w_acc),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_lbl     (o_lbl)
    );

endmodule
`default_nettype wire

@@ hw/rtl/lbp_chk.sv @@
// Port-level checker of the LBP core and its bind.
`default_nettype none
`include "uniform_lbp_3x3_core_macros.svh"
module lbp_chk import lbp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [LBL_W-1:0] i_label,
    input logic             i_last,
    input logic             i_pready
);

    `LBP_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_label) && $stable(i_last), "label beat dropped or changed while stalled")
    `LBP_ASSERT_RST(a_label_range, i_clk, i_rst_n, i_out_valid |-> i_label <= LBL_W'(LABEL_MAX), "label above uniform rank range")
    `LBP_ASSERT_ANY(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "label beat right after reset")
    `LBP_ASSERT_ANY(a_pready, i_clk, i_pready, "pready dropped")

endmodule

bind uniform_lbp_3x3_core lbp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_lbl.valid),
    .i_out_ready (o_lbl.ready),
    .i_label     (o_lbl.label),
    .i_last      (o_lbl.last),
    .i_pready    (pready)
);
`default_nettype wire

@@ verif/uniform_lbp_3x3_core_tb.sv @@
// Self-checking testbench for uniform_lbp_3x3_core: streams frames and checks labels.
`timescale 1ns / 100ps
module uniform_lbp_3x3_core_tb;
    import lbp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PIXELS = 500;
    localparam int NB_IDX [8] = '{3, 6, 7, 8, 5, 2, 1, 0};

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             typed;
        logic [LBL_W-1:0] label;
        logic             last;
    } t_dir_row;

    typedef struct packed {
        logic [LBL_W-1:0] label;
        logic             last;
    } t_label_beat;

    logic i_clk;
    logic i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lbp_pix_if pix_bus ();
    lbp_lbl_if lbl_bus ();

    uniform_lbp_3x3_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_lbl   (lbl_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // directed frames at 3x3: flat, bright center, alternating ring
    t_dir_row dir_rows [27] = '{
        '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b0, 6'd0, 1'b0},
        '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b0, 6'd0, 1'b0},
        '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b0, 6'd0, 1'b0}, '{8'd7, 1'b1, 6'd58, 1'b1},
        '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b0, 6'd0, 1'b0},
        '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd255, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b0, 6'd0, 1'b0},
        '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b1, 6'd1, 1'b1},
        '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd255, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b0, 6'd0, 1'b0},
        '{8'd255, 1'b0, 6'd0, 1'b0}, '{8'd100, 1'b0, 6'd0, 1'b0}, '{8'd255, 1'b0, 6'd0, 1'b0},
        '{8'd0, 1'b0, 6'd0, 1'b0}, '{8'd255, 1'b0, 6'd0, 1'b0}, '{8'd0, 1'b1, 6'd0, 1'b1}
    };

    // predictor state
    logic [PIX_W-1:0] line_prev  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] line_prev2 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [9];
    logic [LBL_W-1:0] rank_of_code [256];
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    int unsigned      col_pos;
    int unsigned      row_pos;

    t_label_beat pending_labels [$];

    bit steady_run;
    int pixel_style;
    int errors;
    int cycle_count;
    int pixels_fed;
    int labels_checked;
    int geometry_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d labels still pending", $time, pending_labels.size());
            $display("uniform_lbp_3x3_core verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        lbl_bus.ready <= steady_run || ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin : check_labels
        t_label_beat exp_beat;
        if (i_rst_n && lbl_bus.valid && lbl_bus.ready) begin
            if (pending_labels.size() == 0) begin
                $display("%0t: unexpected beat label %0d last %0b", $time,
                         lbl_bus.label, lbl_bus.last);
                errors++;
            end else begin
                exp_beat = pending_labels.pop_front();
                labels_checked++;
                if (lbl_bus.label !== exp_beat.label) begin
                    $display("%0t: label mismatch exp %0d got %0d", $time,
                             exp_beat.label, lbl_bus.label);
                    errors++;
                end
                if (lbl_bus.last !== exp_beat.last) begin
                    $display("%0t: last mismatch exp %0b got %0b", $time,
                             exp_beat.last, lbl_bus.last);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] value, int unsigned top);
        if (value < MIN_SIZE) return MIN_SIZE;
        if (value > top) return top;
        return value;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel();
        case (pixel_style)
            0: return PIX_W'($urandom_range(0, 255));
            1: return PIX_W'(100 + $urandom_range(0, 2));
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return PIX_W'(124 + $urandom_range(0, 8));
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] exp_val);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata !== APB_DW'(exp_val)) begin
            $display("%0t: register read mismatch at %0d exp %0d got %0d", $time,
                     addr, exp_val, rdata);
            errors++;
        end
    endtask

    // only while idle: all labels returned, pipeline drained
    task automatic set_geometry(input int width, input int height);
        logic [APB_DW-1:0] unused;
        pix_bus.valid <= 1'b0;
        while (pending_labels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_width  = CFG_W'(width);
        cfg_height = CFG_W'(height);
        apb_access(1'b1, APB_AW'({REG_WIDTH, 2'b00}), APB_DW'(cfg_width), unused);
        apb_access(1'b1, APB_AW'({REG_HEIGHT, 2'b00}), APB_DW'(cfg_height), unused);
        check_reg(APB_AW'({REG_WIDTH, 2'b00}), cfg_width);
        check_reg(APB_AW'({REG_HEIGHT, 2'b00}), cfg_height);
        geometry_count++;
        pixel_style = $urandom_range(0, 3);
    endtask

    // drive one pixel beat, then advance the reference window and counters
    task automatic feed_pixel(input logic [PIX_W-1:0] px, input logic typed,
                              input logic [LBL_W-1:0] typed_label, input logic typed_last);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [7:0]       code;
        t_label_beat      beat;
        while (!steady_run && $urandom_range(99) < 25) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= px;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        pixels_fed++;

        w   = clamp_size(cfg_width, MAX_WIDTH_DEF);
        h   = clamp_size(cfg_height, HEIGHT_LIMIT);
        top = line_prev2[col_pos];
        mid = line_prev[col_pos];
        line_prev2[col_pos] = mid;
        line_prev[col_pos]  = px;
        win[0] = win[1]; win[1] = win[2]; win[2] = top;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;

        if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
            for (int b = 0; b < 8; b++) code[b] = (win[NB_IDX[b]] >= win[4]);
            beat.label = rank_of_code[code];
            beat.last  = (row_pos == h - 1) && (col_pos == w - 1);
            if (typed) begin
                beat.label = typed_label;
                beat.last  = typed_last;
            end
            pending_labels.push_back(beat);
        end else if (typed) begin
            pending_labels.push_back('{typed_label, typed_last});
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic stream(input int count);
        repeat (count) feed_pixel(next_pixel(), 1'b0, '0, 1'b0);
    endtask

    // runs to the end of the current frame, then n-1 whole frames more
    task automatic run_frames(input int n);
        repeat (n) begin
            do feed_pixel(next_pixel(), 1'b0, '0, 1'b0);
            while (!(col_pos == 0 && row_pos == 0));
        end
    endtask

    initial begin : main
        logic [7:0] v8;
        int         flips;
        int         rank;
        int         random_start;

        rank = 0;
        for (int v = 0; v < 256; v++) begin
            v8    = 8'(v);
            flips = 0;
            for (int b = 0; b < 8; b++) flips += (v8[b] != v8[(b + 1) % 8]);
            if (flips <= 2) begin
                rank++;
                rank_of_code[v] = LBL_W'(rank);
            end else begin
                rank_of_code[v] = '0;
            end
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_pos     = 0;
        row_pos     = 0;
        cfg_width   = WIDTH_RESET;
        cfg_height  = HEIGHT_RESET;
        steady_run  = 1'b0;
        pixel_style = 0;

        i_rst_n       = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        lbl_bus.ready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_reg(APB_AW'({REG_WIDTH, 2'b00}), WIDTH_RESET);
        check_reg(APB_AW'({REG_HEIGHT, 2'b00}), HEIGHT_RESET);

        set_geometry(3, 3);
        foreach (dir_rows[i])
            feed_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].label, dir_rows[i].last);

        // sizes below the minimum saturate to 3
        set_geometry(0, 1);
        run_frames(2);
        set_geometry(2, 2);
        run_frames(1);

        // widest line, no stalls on either side; cut to 3x3 in the second row
        steady_run = 1'b1;
        set_geometry(2047, 3);
        stream(1030);
        steady_run = 1'b0;
        set_geometry(3, 3);
        run_frames(1);

        // height cut mid-frame below the current row: row runs out, frame wraps
        set_geometry(3, 1024);
        stream(15);
        set_geometry(3, 3);
        run_frames(2);

        // height cut mid-frame above the current row
        set_geometry(5, 2047);
        stream(60);
        set_geometry(5, 13);
        run_frames(2);

        // width cut mid-frame past the current column
        set_geometry(20, 6);
        stream(75);
        set_geometry(8, 6);
        run_frames(2);

        random_start = pixels_fed;
        while (pixels_fed - random_start < RANDOM_PIXELS) begin
            case ($urandom_range(0, 7))
                0:       set_geometry($urandom_range(0, 2), $urandom_range(0, 8));
                1:       set_geometry($urandom_range(17, 48), $urandom_range(3, 5));
                default: set_geometry($urandom_range(3, 16), $urandom_range(3, 8));
            endcase
            run_frames($urandom_range(1, 3));
        end

        pix_bus.valid <= 1'b0;
        while (pending_labels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("fed %0d pixels over %0d frame geometries, %0d labels checked", pixels_fed,
                 geometry_count, labels_checked);
        $display("geometries include saturated sizes, 1024-wide lines and mid-frame changes");
        if (errors == 0) begin
            $display("uniform_lbp_3x3_core verification clean");
        end else begin
            $display("uniform_lbp_3x3_core verification failed");
        end
        $finish;
    end

endmodule
